// ----- design/riscv_m_multiply_divide_unit_core_defines.svh -----
// Assertion helpers for the multiply/divide unit.
`ifndef RISCV_M_MULTIPLY_DIVIDE_UNIT_CORE_DEFINES_SVH
`define RISCV_M_MULTIPLY_DIVIDE_UNIT_CORE_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define RMDU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMDU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rmdu_pkg.sv -----
`default_nettype none
package rmdu_pkg;
    localparam int FIELD_W          = 64;
    localparam int REQ_W            = 4;
    localparam int DEFAULT_MAX_XLEN = 64;

    typedef enum logic [REQ_W-1:0] {
        OP_MUL    = 4'd0,
        OP_MULH   = 4'd1,
        OP_MULHSU = 4'd2,
        OP_MULHU  = 4'd3,
        OP_DIV    = 4'd4,
        OP_DIVU   = 4'd5,
        OP_REM    = 4'd6,
        OP_REMU   = 4'd7,
        OP_MULW   = 4'd8,
        OP_DIVW   = 4'd9,
        OP_DIVUW  = 4'd10,
        OP_REMW   = 4'd11,
        OP_REMUW  = 4'd12
    } op_t;
endpackage
`default_nettype wire

// ----- design/riscv_m_multiply_divide_unit_core.sv -----
// channel | dir | handshake             | payload
// s_      | in  | s_tvalid / s_tready   | s_tdata {src_b, src_a}, s_tuser req_type
// m_      | out | m_tvalid / m_tready   | m_tdata result_value, m_tuser illegal_op
// cfg_    | in  | cfg_valid / cfg_ready | cfg_data xlen_is_64
//
// Path from the input transaction to m_tvalid: decode register, MAX_XLEN
// restoring divide stages (one quotient bit each; the multiplier runs
// alongside), output register.
// One transaction per cycle sustained while the skid register is empty.
// Reset clears valid bits and sets xlen_is_64; no clearing pass.
// A skid register behind the output keeps the pipeline moving when the
// output first stalls; the whole pipeline holds while the skid is full.
`default_nettype none
`include "riscv_m_multiply_divide_unit_core_defines.svh"
module riscv_m_multiply_divide_unit_core
    import rmdu_pkg::*;
#(
    parameter int MAX_XLEN = DEFAULT_MAX_XLEN
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [2*FIELD_W-1:0] s_tdata,  // src_a, src_b
    input  wire logic [REQ_W-1:0]     s_tuser,  // req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [FIELD_W-1:0]   m_tdata,  // result_value
    output logic      [0:0]           m_tuser,  // illegal_op
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [0:0]           cfg_data  // xlen_is_64
);
    localparam int  XW     = MAX_XLEN;
    localparam bit  HAS64  = (MAX_XLEN >= 64);
    localparam int  NSTAGE = XW + 1;

    typedef struct packed {
        logic          ill;
        logic          nar;
        logic          is_word;
        logic          is_div;
        logic          want_rem;
        logic          is_mulh;
        logic          bzero;
        logic          neg_q;
        logic          neg_r;
        logic [XW-1:0] a_op;
    } meta_t;

    logic          xlen_reg;
    logic          en;
    logic          v_reg    [NSTAGE];
    meta_t         meta_reg [NSTAGE];
    meta_t         meta_next;
    logic [XW-1:0] mag_a_reg, mag_b_reg, mag_a_next, mag_b_next;
    logic          negp_reg, negp_next;
    logic [2*XW-1:0] prod;
    logic [XW-1:0] quo, rem;
    logic [FIELD_W-1:0] res_next, out_reg, skid_reg;
    logic          ill_out_reg, skid_ill_reg;
    logic          m_v_reg, skid_v_reg;

    assign cfg_ready = 1'b1;
    assign en        = !skid_v_reg;
    assign s_tready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xlen_reg <= 1'b1;
        end else if (cfg_valid) begin
            xlen_reg <= cfg_data[0];
        end
    end

    // decode
    always_comb begin
        op_t           op;
        logic [FIELD_W-1:0] a_in, b_in;
        logic          w64, sa, sb, na, nb;
        logic [XW-1:0] a_op, b_op, neg_a, neg_b;
        op   = op_t'(s_tuser);
        a_in = s_tdata[FIELD_W-1:0];
        b_in = s_tdata[2*FIELD_W-1:FIELD_W];
        w64  = xlen_reg && HAS64;
        meta_next.is_word = (op == OP_MULW) || (op == OP_DIVW) || (op == OP_DIVUW)
                         || (op == OP_REMW) || (op == OP_REMUW);
        meta_next.ill = (s_tuser > OP_REMUW) || (meta_next.is_word && !w64);
        meta_next.nar = !w64 || meta_next.is_word;
        a_op = meta_next.nar ? XW'(a_in[31:0]) : a_in[XW-1:0];
        b_op = meta_next.nar ? XW'(b_in[31:0]) : b_in[XW-1:0];
        sa = (op == OP_MULH) || (op == OP_MULHSU) || (op == OP_DIV) || (op == OP_REM)
          || (op == OP_DIVW) || (op == OP_REMW);
        sb = (op == OP_MULH) || (op == OP_DIV) || (op == OP_REM)
          || (op == OP_DIVW) || (op == OP_REMW);
        na = sa && (meta_next.nar ? a_in[31] : a_in[XW-1]);
        nb = sb && (meta_next.nar ? b_in[31] : b_in[XW-1]);
        neg_a = XW'(0) - a_op;
        neg_b = XW'(0) - b_op;
        mag_a_next = na ? (meta_next.nar ? XW'(neg_a[31:0]) : neg_a) : a_op;
        mag_b_next = nb ? (meta_next.nar ? XW'(neg_b[31:0]) : neg_b) : b_op;
        negp_next  = na ^ nb;
        meta_next.is_div = (op == OP_DIV) || (op == OP_DIVU) || (op == OP_REM)
                        || (op == OP_REMU) || (op == OP_DIVW) || (op == OP_DIVUW)
                        || (op == OP_REMW) || (op == OP_REMUW);
        meta_next.want_rem = (op == OP_REM) || (op == OP_REMU) || (op == OP_REMW)
                          || (op == OP_REMUW);
        meta_next.is_mulh  = (op == OP_MULH) || (op == OP_MULHSU) || (op == OP_MULHU);
        meta_next.bzero    = (b_op == '0);
        meta_next.neg_q    = na ^ nb;
        meta_next.neg_r    = na;
        meta_next.a_op     = a_op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSTAGE; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= s_tvalid;
            for (int i = 1; i < NSTAGE; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_reg[0] <= meta_next;
            mag_a_reg   <= mag_a_next;
            mag_b_reg   <= mag_b_next;
            negp_reg    <= negp_next;
            for (int i = 1; i < NSTAGE; i++) begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    rmdu_mul #(.XW(XW), .LAT(XW)) u_mul (
        .aclk  (aclk),
        .en    (en),
        .mag_a (mag_a_reg),
        .mag_b (mag_b_reg),
        .neg   (negp_reg),
        .prod  (prod)
    );

    rmdu_div #(.XW(XW)) u_div (
        .aclk     (aclk),
        .en       (en),
        .dividend (mag_a_reg),
        .divisor  (mag_b_reg),
        .quo      (quo),
        .rem      (rem)
    );

    // result select
    always_comb begin
        meta_t         m;
        logic [XW-1:0] base, signed_val, res_x;
        logic [31:0]   r32;
        m          = meta_reg[NSTAGE-1];
        base       = m.want_rem ? rem : quo;
        signed_val = (m.want_rem ? m.neg_r : m.neg_q) ? (XW'(0) - base) : base;
        if (m.is_div) begin
            if (m.bzero) begin
                res_x = m.want_rem ? m.a_op : '1;
            end else begin
                res_x = signed_val;
            end
        end else if (m.is_mulh) begin
            res_x = m.nar ? XW'(prod[63:32]) : prod[2*XW-1:XW];
        end else begin
            res_x = prod[XW-1:0];
        end
        r32 = res_x[31:0];
        if (m.ill) begin
            res_next = '0;
        end else if (m.nar) begin
            res_next = m.is_word ? {{(FIELD_W-32){r32[31]}}, r32} : FIELD_W'(r32);
        end else begin
            res_next = FIELD_W'(res_x);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg    <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_tready) begin
                skid_v_reg <= 1'b0;
            end
        end else if (v_reg[NSTAGE-1]) begin
            if (!m_v_reg || m_tready) begin
                m_v_reg <= 1'b1;
            end else begin
                skid_v_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_tready) begin
                out_reg     <= skid_reg;
                ill_out_reg <= skid_ill_reg;
            end
        end else if (v_reg[NSTAGE-1]) begin
            if (!m_v_reg || m_tready) begin
                out_reg     <= res_next;
                ill_out_reg <= meta_reg[NSTAGE-1].ill;
            end else begin
                skid_reg     <= res_next;
                skid_ill_reg <= meta_reg[NSTAGE-1].ill;
            end
        end
    end

    assign m_tvalid   = m_v_reg;
    assign m_tdata    = out_reg;
    assign m_tuser[0] = ill_out_reg;

    `RMDU_ASSERT_IMP(a_skid_needs_out, skid_v_reg, m_v_reg, "skid full with empty output")
    `RMDU_ASSERT_NXT(a_skid_holds, skid_v_reg && !m_tready, skid_v_reg, "skid lost data")
    `RMDU_ASSERT_IMP(a_illegal_zero, m_v_reg && ill_out_reg, out_reg == '0,
        "illegal op with nonzero result")
endmodule
`default_nettype wire

// ----- design/rmdu_mul.sv -----
`default_nettype none
module rmdu_mul
    import rmdu_pkg::*;
#(
    parameter int XW  = DEFAULT_MAX_XLEN,
    parameter int LAT = DEFAULT_MAX_XLEN
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [XW-1:0]   mag_a,
    input  wire logic [XW-1:0]   mag_b,
    input  wire logic            neg,
    output logic      [2*XW-1:0] prod
);
    localparam int H = XW / 2;

    logic [2*H-1:0]  pp0_reg, pp1_reg, pp2_reg, pp3_reg;
    logic            neg1_reg, neg2_reg;
    logic [2*XW-1:0] sum_reg, sum_next;
    logic [2*XW-1:0] p_reg;
    logic [2*XW-1:0] dly_reg [LAT-3];

    always_comb begin
        sum_next = (2*XW)'(pp0_reg)
                 + ((2*XW)'(pp1_reg) << H)
                 + ((2*XW)'(pp2_reg) << H)
                 + ((2*XW)'(pp3_reg) << (2*H));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp0_reg  <= mag_a[H-1:0]    * mag_b[H-1:0];
            pp1_reg  <= mag_a[XW-1:H]   * mag_b[H-1:0];
            pp2_reg  <= mag_a[H-1:0]    * mag_b[XW-1:H];
            pp3_reg  <= mag_a[XW-1:H]   * mag_b[XW-1:H];
            neg1_reg <= neg;
            sum_reg  <= sum_next;
            neg2_reg <= neg1_reg;
            p_reg    <= neg2_reg ? ((2*XW)'(0) - sum_reg) : sum_reg;
            dly_reg[0] <= p_reg;
            for (int i = 1; i < LAT - 3; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign prod = dly_reg[LAT-4];
endmodule
`default_nettype wire

// ----- design/rmdu_div.sv -----
`default_nettype none
module rmdu_div
    import rmdu_pkg::*;
#(
    parameter int XW = DEFAULT_MAX_XLEN
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [XW-1:0] dividend,
    input  wire logic [XW-1:0] divisor,
    output logic      [XW-1:0] quo,
    output logic      [XW-1:0] rem
);
    logic [XW-1:0] rem_reg [XW];
    logic [XW-1:0] quo_reg [XW];
    logic [XW-1:0] dvs_reg [XW-1];
    logic [XW-1:0] rem_next [XW];
    logic [XW-1:0] quo_next [XW];

    always_comb begin
        logic [XW-1:0] r_in, q_in, d_in;
        logic [XW:0]   tmp, dif;
        for (int i = 0; i < XW; i++) begin
            r_in = (i == 0) ? '0       : rem_reg[(i == 0) ? 0 : i-1];
            q_in = (i == 0) ? dividend : quo_reg[(i == 0) ? 0 : i-1];
            d_in = (i == 0) ? divisor  : dvs_reg[(i == 0) ? 0 : i-1];
            tmp  = {r_in, q_in[XW-1]};
            dif  = tmp - {1'b0, d_in};
            if (!dif[XW]) begin
                rem_next[i] = dif[XW-1:0];
                quo_next[i] = {q_in[XW-2:0], 1'b1};
            end else begin
                rem_next[i] = tmp[XW-1:0];
                quo_next[i] = {q_in[XW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dvs_reg[0] <= divisor;
            for (int i = 0; i < XW; i++) begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
            for (int i = 1; i < XW - 1; i++) begin
                dvs_reg[i] <= dvs_reg[i-1];
            end
        end
    end

    assign quo = quo_reg[XW-1];
    assign rem = rem_reg[XW-1];
endmodule
`default_nettype wire
